/* src/keyed_directed_graph_store_macros.svh */
// Assertion macros for the keyed directed graph store.
// No dependencies; included by the top level only.
`ifndef KEYED_DIRECTED_GRAPH_STORE_MACROS_SVH
`define KEYED_DIRECTED_GRAPH_STORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define KDG_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("kdg assertion failed");

// Next-cycle implication.
`define KDG_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("kdg assertion failed");

`else

`define KDG_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define KDG_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* src/kdg_pkg.sv */
// Shared types and constants for the keyed directed graph store.
// No dependencies; used by kdg_ctrl, kdg_dp and the top level.
package kdg_pkg;

    localparam int MAX_NODES_DEF = 16;
    localparam int KEY_BITS_DEF  = 64;

    // Fixed port widths
    localparam int KEY_W       = 64;
    localparam int KIND_W      = 3;
    localparam int SLOT_OUT_W  = 4;
    localparam int COUNT_OUT_W = 5;

    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef enum logic [KIND_W-1:0] {
        KIND_ADDED     = 3'd0,
        KIND_EXISTS    = 3'd1,
        KIND_FULL      = 3'd2,
        KIND_NOT_FOUND = 3'd3,
        KIND_OUTGOING  = 3'd4,
        KIND_INCOMING  = 3'd5,
        KIND_DONE      = 3'd6
    } kind_t;

    // Controller -> datapath
    typedef struct packed {
        logic  load;        // latch keys, clear counters
        logic  scan_clr;    // restart the table walk
        logic  scan_run;    // walk the table one slot per cycle
        logic  tgt_b;       // compare / allocate against the destination key
        logic  take_hit;    // slot register <- matched slot
        logic  take_alloc;  // allocate next free slot for the target key
        logic  to_v;        // slot goes to v (else u)
        logic  load_row;    // copy edge row u
        logic  in_mode;     // walk edge column u instead of row copy
        logic  set_edge;    // set edge u -> v
        logic  emit;        // load output word
        kind_t emit_kind;
        logic  emit_last;
    } kdg_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic hit;       // key read this cycle matches target
        logic drained;   // walk finished, nothing in flight
        logic room;      // a free slot exists
        logic edge_set;  // edge u -> v present
        logic nb;        // neighbor bit set for slot read this cycle
    } kdg_stat_t;

endpackage

/* src/kdg_ctrl.sv */
// Controller FSM for the keyed directed graph store.
// Depends on kdg_pkg; drives kdg_dp through kdg_cmd_t.
module kdg_ctrl
    import kdg_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  logic      cmd,
    input  kdg_stat_t stat,
    output kdg_cmd_t  ctl,
    output logic      busy
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SRCH_A,
        S_SRCH_B,
        S_EDGE,
        S_SRCH_Q,
        S_LOAD_ROW,
        S_OUT_SCAN,
        S_IN_SCAN
    } state_t;

    state_t state_reg, state_next;
    logic   busy_reg, busy_next;

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctl.load   = 1'b1;
                    state_next = (cmd == CMD_QUERY) ? S_SRCH_Q : S_SRCH_A;
                end
            end
            S_SRCH_A, S_SRCH_B:
            begin
                ctl.scan_run = 1'b1;
                ctl.tgt_b    = (state_reg == S_SRCH_B);
                ctl.to_v     = (state_reg == S_SRCH_B);
                priority if (stat.hit)
                begin
                    ctl.take_hit = 1'b1;
                    ctl.scan_clr = 1'b1;
                    state_next   = (state_reg == S_SRCH_B) ? S_EDGE : S_SRCH_B;
                end
                else if (stat.drained)
                begin
                    if (stat.room)
                    begin
                        ctl.take_alloc = 1'b1;
                        ctl.scan_clr   = 1'b1;
                        state_next     = (state_reg == S_SRCH_B) ? S_EDGE : S_SRCH_B;
                    end
                    else
                    begin
                        ctl.emit      = 1'b1;
                        ctl.emit_kind = KIND_FULL;
                        ctl.emit_last = 1'b1;
                        state_next    = S_IDLE;
                    end
                end
                else
                begin
                    // still walking
                    state_next = state_reg;
                end
            end
            S_EDGE:
            begin
                ctl.emit      = 1'b1;
                ctl.emit_last = 1'b1;
                if (stat.edge_set)
                begin
                    ctl.emit_kind = KIND_EXISTS;
                end
                else
                begin
                    ctl.set_edge  = 1'b1;
                    ctl.emit_kind = KIND_ADDED;
                end
                state_next = S_IDLE;
            end
            S_SRCH_Q:
            begin
                ctl.scan_run = 1'b1;
                priority if (stat.hit)
                begin
                    ctl.take_hit = 1'b1;
                    ctl.scan_clr = 1'b1;
                    state_next   = S_LOAD_ROW;
                end
                else if (stat.drained)
                begin
                    ctl.emit      = 1'b1;
                    ctl.emit_kind = KIND_NOT_FOUND;
                    ctl.emit_last = 1'b1;
                    state_next    = S_IDLE;
                end
                else
                begin
                    state_next = state_reg;
                end
            end
            S_LOAD_ROW:
            begin
                ctl.load_row = 1'b1;
                state_next   = S_OUT_SCAN;
            end
            S_OUT_SCAN:
            begin
                ctl.scan_run = 1'b1;
                priority if (stat.drained)
                begin
                    ctl.scan_clr = 1'b1;
                    state_next   = S_IN_SCAN;
                end
                else if (stat.nb)
                begin
                    ctl.emit      = 1'b1;
                    ctl.emit_kind = KIND_OUTGOING;
                end
                else
                begin
                    state_next = state_reg;
                end
            end
            S_IN_SCAN:
            begin
                ctl.scan_run = 1'b1;
                ctl.in_mode  = 1'b1;
                priority if (stat.drained)
                begin
                    ctl.emit      = 1'b1;
                    ctl.emit_kind = KIND_DONE;
                    ctl.emit_last = 1'b1;
                    state_next    = S_IDLE;
                end
                else if (stat.nb)
                begin
                    ctl.emit      = 1'b1;
                    ctl.emit_kind = KIND_INCOMING;
                end
                else
                begin
                    state_next = state_reg;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        busy_next = (state_next != S_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
        end
    end

    assign busy = busy_reg;

endmodule

/* src/kdg_dp.sv */
// Datapath for the keyed directed graph store: key memory, edge matrix,
// table walker and output word register. Depends on kdg_pkg.
module kdg_dp
    import kdg_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF,
    parameter int KEY_BITS  = KEY_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [KEY_W-1:0]       src_key,
    input  logic [KEY_W-1:0]       dst_key,
    input  kdg_cmd_t               ctl,
    output kdg_stat_t              stat,
    output logic                   valid,
    output logic [KIND_W-1:0]      kind,
    output logic [KEY_W-1:0]       neighbor_key,
    output logic [SLOT_OUT_W-1:0]  neighbor_slot,
    output logic [COUNT_OUT_W-1:0] succ_count,
    output logic [COUNT_OUT_W-1:0] pred_count,
    output logic                   last
);

    localparam int SLOT_W = $clog2(MAX_NODES);
    localparam int CNT_W  = $clog2(MAX_NODES + 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_NODES);

    // Key table: undefined until written, only slots below count are read
    logic [KEY_BITS-1:0]  key_mem [MAX_NODES];
    logic [MAX_NODES-1:0] edge_reg [MAX_NODES];

    logic [KEY_BITS-1:0]  a_reg, b_reg;
    logic [CNT_W-1:0]     count_reg, scan_reg;
    logic [SLOT_W-1:0]    u_reg, v_reg;
    logic [KEY_BITS-1:0]  rd_key_reg;
    logic [SLOT_W-1:0]    rd_slot_reg;
    logic                 rd_vld_reg, rd_bit_reg;
    logic [MAX_NODES-1:0] row_reg;
    logic [CNT_W-1:0]     out_cnt_reg, in_cnt_reg;

    logic                   valid_reg;
    kind_t                  kind_reg;
    logic [KEY_W-1:0]       nkey_reg;
    logic [SLOT_OUT_W-1:0]  nslot_reg;
    logic [COUNT_OUT_W-1:0] ocnt_reg, icnt_reg;
    logic                   last_reg;

    logic [KEY_BITS-1:0]  tgt;
    logic                 issue;
    logic [SLOT_W-1:0]    scan_idx, row_addr, take_slot;
    logic [MAX_NODES-1:0] row_rd;
    logic                 nb_kind, done_kind;

    assign tgt       = ctl.tgt_b ? b_reg : a_reg;
    assign issue     = ctl.scan_run && !ctl.scan_clr && (scan_reg < count_reg);
    assign scan_idx  = scan_reg[SLOT_W-1:0];
    assign row_addr  = ctl.in_mode ? scan_idx : u_reg;
    assign row_rd    = edge_reg[row_addr];
    assign take_slot = ctl.take_hit ? rd_slot_reg : count_reg[SLOT_W-1:0];
    assign nb_kind   = (ctl.emit_kind == KIND_OUTGOING) || (ctl.emit_kind == KIND_INCOMING);
    assign done_kind = (ctl.emit_kind == KIND_DONE);

    assign stat.hit      = rd_vld_reg && (rd_key_reg == tgt);
    assign stat.drained  = !rd_vld_reg && (scan_reg == count_reg);
    assign stat.room     = (count_reg < MAX_CNT);
    assign stat.edge_set = row_rd[v_reg];
    assign stat.nb       = rd_vld_reg && rd_bit_reg;

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            scan_reg   <= '0;
            rd_vld_reg <= 1'b0;
            valid_reg  <= 1'b0;
            for (int i = 0; i < MAX_NODES; i++)
            begin
                edge_reg[i] <= '0;
            end
        end
        else
        begin
            if (ctl.load || ctl.scan_clr)
            begin
                scan_reg   <= '0;
                rd_vld_reg <= 1'b0;
            end
            else
            begin
                if (issue)
                begin
                    scan_reg <= scan_reg + CNT_W'(1);
                end
                rd_vld_reg <= issue;
            end
            if (ctl.take_alloc)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            if (ctl.set_edge)
            begin
                edge_reg[u_reg][v_reg] <= 1'b1;
            end
            valid_reg <= ctl.emit;
        end
    end

    // Key memory
    always_ff @(posedge clk)
    begin
        if (ctl.take_alloc)
        begin
            key_mem[count_reg[SLOT_W-1:0]] <= tgt;
        end
        if (issue)
        begin
            rd_key_reg <= key_mem[scan_idx];
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            a_reg       <= src_key[KEY_BITS-1:0];
            b_reg       <= dst_key[KEY_BITS-1:0];
            out_cnt_reg <= '0;
            in_cnt_reg  <= '0;
        end
        else if (ctl.emit)
        begin
            if (ctl.emit_kind == KIND_OUTGOING)
            begin
                out_cnt_reg <= out_cnt_reg + CNT_W'(1);
            end
            if (ctl.emit_kind == KIND_INCOMING)
            begin
                in_cnt_reg <= in_cnt_reg + CNT_W'(1);
            end
        end
        if (issue)
        begin
            rd_slot_reg <= scan_idx;
            rd_bit_reg  <= ctl.in_mode ? row_rd[u_reg] : row_reg[scan_idx];
        end
        if (ctl.take_hit || ctl.take_alloc)
        begin
            if (ctl.to_v)
            begin
                v_reg <= take_slot;
            end
            else
            begin
                u_reg <= take_slot;
            end
        end
        if (ctl.load_row)
        begin
            row_reg <= row_rd;
        end
        if (ctl.emit)
        begin
            kind_reg  <= ctl.emit_kind;
            nkey_reg  <= nb_kind ? KEY_W'(rd_key_reg) : '0;
            nslot_reg <= nb_kind ? SLOT_OUT_W'(rd_slot_reg) : '0;
            ocnt_reg  <= done_kind ? COUNT_OUT_W'(out_cnt_reg) : '0;
            icnt_reg  <= done_kind ? COUNT_OUT_W'(in_cnt_reg) : '0;
            last_reg  <= ctl.emit_last;
        end
    end

    assign valid         = valid_reg;
    assign kind          = kind_reg;
    assign neighbor_key  = nkey_reg;
    assign neighbor_slot = nslot_reg;
    assign succ_count    = ocnt_reg;
    assign pred_count    = icnt_reg;
    assign last          = last_reg;

endmodule

/* src/keyed_directed_graph_store.sv */
// Top level of the keyed directed graph store.
// Depends on kdg_pkg, kdg_ctrl, kdg_dp and keyed_directed_graph_store_macros.svh.
//
// Usage:
//   Command channel: drive cmd/src_key/dst_key with start high; the word is
//   taken at a clock edge where start is high and busy is low. busy rises the
//   cycle after and falls in the cycle the last result word is shown.
//   Result channel: each word is on kind..last for exactly one cycle with
//   valid high. The receiver cannot stall; results are never held back.
//   An add-edge command gives one word (added, exists or full), last = 1.
//   A query gives not-found, or the outgoing neighbors, the incoming
//   neighbors (both in slot order) and a done word carrying both counts.
// Sequence:
//   Every key search walks the key memory one slot a cycle through a
//   registered read port. Add-edge: two searches plus the edge update.
//   Query: search, row load and two full walks. The last word shows in
//   the cycle busy drops. One command at a time; the next may start in
//   the last result's cycle.
// Reset: node count and the edge matrix are cleared at once; the key
//   memory needs no clearing since only allocated slots are read.
`include "keyed_directed_graph_store_macros.svh"

module keyed_directed_graph_store
    import kdg_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF,
    parameter int KEY_BITS  = KEY_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic                   cmd,
    input  logic [KEY_W-1:0]       src_key,
    input  logic [KEY_W-1:0]       dst_key,
    output logic                   valid,
    output logic [KIND_W-1:0]      kind,
    output logic [KEY_W-1:0]       neighbor_key,
    output logic [SLOT_OUT_W-1:0]  neighbor_slot,
    output logic [COUNT_OUT_W-1:0] succ_count,
    output logic [COUNT_OUT_W-1:0] pred_count,
    output logic                   last
);

    kdg_cmd_t  ctl;
    kdg_stat_t stat;
    logic      nb_word;

    // Sequencer: search, allocate, edge update, neighbor walks
    kdg_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .cmd   (cmd),
        .stat  (stat),
        .ctl   (ctl),
        .busy  (busy)
    );

    // Storage and the output word register
    kdg_dp #(
        .MAX_NODES (MAX_NODES),
        .KEY_BITS  (KEY_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .src_key       (src_key),
        .dst_key       (dst_key),
        .ctl           (ctl),
        .stat          (stat),
        .valid         (valid),
        .kind          (kind),
        .neighbor_key  (neighbor_key),
        .neighbor_slot (neighbor_slot),
        .succ_count    (succ_count),
        .pred_count    (pred_count),
        .last          (last)
    );

    // Word kind is one of the neighbor list kinds
    assign nb_word = (kind == KIND_OUTGOING) || (kind == KIND_INCOMING);

    // Final word of a command coincides with the block going idle
    `KDG_ASSERT_IMP(a_last_idle, clk, rst_n, valid && last, !busy)
    // More words pending means the command is still running
    `KDG_ASSERT_IMP(a_more_busy, clk, rst_n, valid && !last, busy)
    // Neighbor list words are never the final word
    `KDG_ASSERT_IMP(a_nb_not_last, clk, rst_n, valid && nb_word, !last)
    // An accepted command keeps the block busy
    `KDG_ASSERT_NXT(a_accept_busy, clk, rst_n, start && !busy, busy)

endmodule
